>>> rtl/nbsmb_pkg.sv
// ----------------------------------------------------------------------------
// NetBIOS/SMB splitter package
// Shared types, codes and the session header check.
// ----------------------------------------------------------------------------
package nbsmb_pkg;

  localparam int unsigned SEG_OFFSET_BITS = 16;
  localparam int unsigned SEG_PORT_BITS   = 16;
  localparam logic [SEG_PORT_BITS-1:0] OFF_MASK =
    (SEG_OFFSET_BITS >= SEG_PORT_BITS) ? {SEG_PORT_BITS{1'b1}}
                                       : SEG_PORT_BITS'((1 << SEG_OFFSET_BITS) - 1);

  localparam logic [31:0] SMB1_ID = 32'hFF534D42;
  localparam logic [31:0] SMB2_ID = 32'hFE534D42;

  localparam logic [31:0] FLAG_MASK = 32'h00ff0000;
  localparam logic [7:0]  FLAG_CLEAR = 8'h00;
  localparam logic [7:0]  FLAG_SET   = 8'h01;

  localparam logic [7:0] TYPE_MESSAGE    = 8'h00;
  localparam logic [7:0] TYPE_REQUEST    = 8'h81;
  localparam logic [7:0] TYPE_KEEP_ALIVE = 8'h85;

  localparam logic [31:0] HDR_BYTES = 32'd4;

  localparam logic [2:0] BS_FIRST      = 3'd0;
  localparam logic [2:0] BS_SECOND     = 3'd1;
  localparam logic [2:0] BS_THIRD      = 3'd2;
  localparam logic [2:0] BS_HDR_LAST   = 3'd3;
  localparam logic [2:0] BS_JUNK_ENTRY = 3'd4;
  localparam logic [2:0] BS_JUNK_1     = 3'd5;
  localparam logic [2:0] BS_JUNK_2     = 3'd6;
  localparam logic [2:0] BS_JUNK_LAST  = 3'd7;

  typedef enum logic [1:0] {
    STATUS_SEARCH = 2'd0,
    STATUS_FLUSH  = 2'd1,
    STATUS_ABORT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic [SEG_PORT_BITS-1:0] seg_offset;
    logic [31:0]              ahead_word;
    logic                     ahead_valid;
    logic                     abort_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flush_point;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  byte_state;
    logic [63:0] header_shift;
  } frame_state_t;

  typedef struct packed {
    logic        ok;
    logic [24:0] msg_len;
  } hdr_chk_t;

  function automatic hdr_chk_t check_hdr(input logic [31:0] hdr, input logic junk,
                                         input logic [31:0] smb_id);
    hdr_chk_t   res;
    logic [7:0] typ;
    logic [7:0] flag;
    logic       type_ok;
    typ  = hdr[31:24];
    flag = 8'((hdr & FLAG_MASK) >> 16);
    if (junk) begin
      type_ok = (typ == TYPE_MESSAGE);
    end else begin
      type_ok = (typ == TYPE_MESSAGE) || ((typ >= TYPE_REQUEST) && (typ <= TYPE_KEEP_ALIVE));
    end
    res.ok = type_ok &&
             !((smb_id == SMB1_ID) && (flag != FLAG_CLEAR) && (flag != FLAG_SET));
    if (smb_id == SMB2_ID) begin
      res.msg_len = {1'b0, hdr[23:0]};
    end else begin
      res.msg_len = {8'b0, flag[0], hdr[15:0]};
    end
    return res;
  endfunction

endpackage

>>> rtl/nbsmb_in_if.sv
// ----------------------------------------------------------------------------
// Splitter input channel
// Valid/ready channel carrying one payload byte and its segment context.
// ----------------------------------------------------------------------------
interface nbsmb_in_if
  import nbsmb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [7:0]               data_byte;
  logic [SEG_PORT_BITS-1:0] seg_offset;
  logic [31:0]              ahead_word;
  logic                     ahead_valid;
  logic                     abort_req;

  modport source (
    output valid, data_byte, seg_offset, ahead_word, ahead_valid, abort_req,
    input  ready
  );

  modport sink (
    input  valid, data_byte, seg_offset, ahead_word, ahead_valid, abort_req,
    output ready
  );
endinterface

>>> rtl/nbsmb_out_if.sv
// ----------------------------------------------------------------------------
// Splitter result channel
// Valid/ready channel carrying the status and flush offset of one word.
// ----------------------------------------------------------------------------
interface nbsmb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] flush_point;

  modport source (
    output valid, status, flush_point,
    input  ready
  );

  modport sink (
    input  valid, status, flush_point,
    output ready
  );
endinterface

>>> rtl/nbsmb_step.sv
// ----------------------------------------------------------------------------
// Splitter step logic
// Next framing state and result for one word, combinational.
// ----------------------------------------------------------------------------
module nbsmb_step
  import nbsmb_pkg::*;
(
  input  in_item_t     item_i,
  input  frame_state_t state_i,
  output frame_state_t state_o,
  output out_item_t    result_o
);

  logic [63:0] shifted;
  logic [31:0] offset;
  logic [31:0] ahead_id;
  hdr_chk_t    chk_hdr;
  hdr_chk_t    chk_junk;
  logic        junk_id_ok;

  assign shifted    = {state_i.header_shift[55:0], item_i.data_byte};
  assign offset     = {{(32 - SEG_PORT_BITS){1'b0}}, item_i.seg_offset & OFF_MASK};
  assign ahead_id   = item_i.ahead_valid ? item_i.ahead_word : 32'd0;
  assign chk_hdr    = check_hdr(shifted[31:0], 1'b0, ahead_id);
  assign chk_junk   = check_hdr(shifted[63:32], 1'b1, shifted[31:0]);
  assign junk_id_ok = (shifted[31:0] == SMB1_ID) || (shifted[31:0] == SMB2_ID);

  always_comb begin
    state_o              = state_i;
    result_o.status      = STATUS_SEARCH;
    result_o.flush_point = 32'd0;
    if (item_i.abort_req) begin
      result_o.status = STATUS_ABORT;
    end else begin
      unique case (state_i.byte_state)
        BS_FIRST: begin
          state_o.header_shift = {56'b0, item_i.data_byte};
          state_o.byte_state   = BS_SECOND;
        end
        BS_HDR_LAST: begin
          state_o.header_shift = shifted;
          if (chk_hdr.ok) begin
            result_o.status      = STATUS_FLUSH;
            result_o.flush_point = {7'b0, chk_hdr.msg_len} + HDR_BYTES + offset
                                   - {29'b0, BS_HDR_LAST};
            state_o.byte_state   = BS_FIRST;
          end else begin
            state_o.byte_state   = BS_JUNK_ENTRY;
          end
        end
        BS_JUNK_LAST: begin
          state_o.header_shift = shifted;
          if (chk_junk.ok && junk_id_ok) begin
            result_o.status      = STATUS_FLUSH;
            result_o.flush_point = {7'b0, chk_junk.msg_len} + HDR_BYTES + offset
                                   - {29'b0, BS_JUNK_LAST};
            state_o.byte_state   = BS_FIRST;
          end
        end
        BS_SECOND, BS_THIRD, BS_JUNK_ENTRY, BS_JUNK_1, BS_JUNK_2: begin
          state_o.header_shift = shifted;
          state_o.byte_state   = state_i.byte_state + 3'd1;
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

>>> rtl/netbios_smb_pdu_splitter.sv
// ----------------------------------------------------------------------------
// NetBIOS session / SMB message splitter
// Finds the end of each NetBIOS-framed SMB message in a byte stream.
// ----------------------------------------------------------------------------
// One payload byte per word, one result word per input word. The block takes
// a word in every cycle unless the result side stalls it. An accepted word
// goes to the input register, which feeds the header check and offset add;
// these load the result register in one pass. While a result waits to be
// taken, the input register takes one more word and then the input stalls
// until the result is taken.
module netbios_smb_pdu_splitter
  import nbsmb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  nbsmb_in_if.sink   in_i,
  nbsmb_out_if.source out_o
);

  in_item_t     in_q;
  logic         in_valid_q;
  out_item_t    out_q;
  out_item_t    out_d;
  logic         out_valid_q;
  frame_state_t state_q;
  frame_state_t state_d;
  logic         advance;
  in_item_t     in_item;

  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign in_item.data_byte   = in_i.data_byte;
  assign in_item.seg_offset  = in_i.seg_offset;
  assign in_item.ahead_word  = in_i.ahead_word;
  assign in_item.ahead_valid = in_i.ahead_valid;
  assign in_item.abort_req   = in_i.abort_req;

  nbsmb_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_item;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.flush_point = out_q.flush_point;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// NetBIOS/SMB splitter testbench
// Drives payload bytes into the splitter, covering good session headers,
// aborts, missing lookahead, junk resync and a random mixed stream. A
// byte-level predictor runs on every accepted word, and each result word is
// checked against the oldest prediction. Both sides idle at random and the
// result side stalls for a long stretch once.
// ----------------------------------------------------------------------------
module testbench
  import nbsmb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  nbsmb_in_if  in_if ();
  nbsmb_out_if out_if ();

  netbios_smb_pdu_splitter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [2:0]  fr_count;
  logic [63:0] fr_shift;
  out_item_t   pending_splits[$];
  int          words_sent;
  int          err_count;
  int          idle_pct;
  int          hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("MISMATCH: %s", msg);
    end
    err_count++;
  endtask

  function automatic logic session_hdr_ok(input logic [31:0] hdr, input logic junk,
                                          input logic [31:0] id, output logic [31:0] len);
    logic [7:0] kind;
    logic [7:0] flag;
    logic       good;
    kind = hdr[31:24];
    flag = hdr[23:16];
    if (junk) begin
      good = (kind == TYPE_MESSAGE);
    end else begin
      good = (kind == TYPE_MESSAGE) || (kind >= TYPE_REQUEST && kind <= TYPE_KEEP_ALIVE);
    end
    if (id == SMB1_ID && flag != FLAG_CLEAR && flag != FLAG_SET) begin
      good = 1'b0;
    end
    if (id == SMB2_ID) begin
      len = {8'h00, hdr[23:0]};
    end else begin
      len = {15'h0000, flag[0], hdr[15:0]};
    end
    return good;
  endfunction

  function automatic out_item_t split_byte(input in_item_t w);
    out_item_t   r;
    logic [31:0] id;
    logic [31:0] len;
    logic [31:0] n;
    r.status      = STATUS_SEARCH;
    r.flush_point = '0;
    n = 32'(w.seg_offset & OFF_MASK);
    if (w.abort_req) begin
      r.status = STATUS_ABORT;
      return r;
    end
    if (fr_count == BS_FIRST) begin
      fr_shift = {56'h0, w.data_byte};
      fr_count = BS_SECOND;
      return r;
    end
    fr_shift = {fr_shift[55:0], w.data_byte};
    if (fr_count == BS_HDR_LAST) begin
      id = w.ahead_valid ? w.ahead_word : 32'h0;
      if (session_hdr_ok(fr_shift[31:0], 1'b0, id, len)) begin
        r.status      = STATUS_FLUSH;
        r.flush_point = len + HDR_BYTES + n - 32'(BS_HDR_LAST);
        fr_count      = BS_FIRST;
      end else begin
        fr_count = BS_JUNK_ENTRY;
      end
    end else if (fr_count == BS_JUNK_LAST) begin
      id = fr_shift[31:0];
      if (session_hdr_ok(fr_shift[63:32], 1'b1, id, len) &&
          (id == SMB1_ID || id == SMB2_ID)) begin
        r.status      = STATUS_FLUSH;
        r.flush_point = len + HDR_BYTES + n - 32'(BS_JUNK_LAST);
        fr_count      = BS_FIRST;
      end
    end else begin
      fr_count = 3'(fr_count + 3'd1);
    end
    return r;
  endfunction

  function automatic in_item_t mk_word(input logic [7:0] b, input logic [15:0] off,
                                       input logic [31:0] ahead, input logic av,
                                       input logic ab);
    in_item_t w;
    w.data_byte   = b;
    w.seg_offset  = off;
    w.ahead_word  = ahead;
    w.ahead_valid = av;
    w.abort_req   = ab;
    return w;
  endfunction

  function automatic logic [15:0] pick_offset();
    if ($urandom_range(3) == 0) begin
      return 16'($urandom_range(3));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      return SMB1_ID;
    end else if (r < 80) begin
      return SMB2_ID;
    end
    return $urandom;
  endfunction

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= w.data_byte;
    in_if.seg_offset  <= w.seg_offset;
    in_if.ahead_word  <= w.ahead_word;
    in_if.ahead_valid <= w.ahead_valid;
    in_if.abort_req   <= w.abort_req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_splits.push_back(split_byte(w));
    words_sent++;
  endtask

  task automatic send_header(input logic [7:0] kind, input logic [7:0] flag,
                             input logic [15:0] len, input logic [31:0] id,
                             input logic av, input logic [15:0] off);
    logic [31:0] hdr;
    hdr = {kind, flag, len};
    for (int i = 0; i < 4; i++) begin
      if (i == 3) begin
        send_word(mk_word(hdr[31-8*i -: 8], 16'(off + i), id, av, 1'b0));
      end else begin
        send_word(mk_word(hdr[31-8*i -: 8], 16'(off + i), $urandom,
                          1'($urandom_range(1)), 1'b0));
      end
    end
  endtask

  task automatic send_resync(input logic [7:0] flag, input logic [15:0] len,
                             input logic [31:0] id, input logic [15:0] off_last);
    logic [63:0] seq;
    seq = {TYPE_MESSAGE, flag, len, id};
    for (int i = 0; i < 8; i++) begin
      send_word(mk_word(seq[63-8*i -: 8], 16'(off_last - 7 + i), $urandom,
                        1'($urandom_range(1)), 1'b0));
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(mk_word(8'($urandom), pick_offset(), $urandom, 1'($urandom_range(1)),
                        $urandom_range(9) == 0));
    end
  endtask

  task automatic test_session_headers();
    send_header(TYPE_MESSAGE, FLAG_SET, 16'hFFFF, SMB1_ID, 1'b1, 16'hFFFC);
    send_header(TYPE_KEEP_ALIVE, 8'hFF, 16'hFFFF, SMB2_ID, 1'b1, 16'h0000);
  endtask

  task automatic test_abort();
    send_word(mk_word(TYPE_REQUEST, 16'h0100, 32'h0, 1'b0, 1'b0));
    send_word(mk_word(8'h07, 16'h0101, 32'h0, 1'b0, 1'b0));
    send_word(mk_word(8'hFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1));
    send_word(mk_word(8'h00, 16'h0102, 32'h0, 1'b0, 1'b0));
    send_word(mk_word(8'h10, 16'h0103, SMB1_ID, 1'b0, 1'b0));
  endtask

  task automatic test_junk_resync();
    send_header(TYPE_MESSAGE, 8'h02, 16'h0000, SMB1_ID, 1'b1, 16'h0000);
    send_resync(FLAG_CLEAR, 16'h0000, SMB1_ID, 16'h0000);
  endtask

  task automatic test_backpressure();
    idle_pct     = 0;
    hold_request = 400;
    send_noise(60);
    idle_pct = 25;
  endtask

  task automatic test_random_stream();
    int unsigned pick;
    int unsigned k;
    logic [7:0]  kind;
    logic [7:0]  flag;
    int          target;
    target = words_sent + 1200;
    while (words_sent < target) begin
      idle_pct = (words_sent > target - 700 && words_sent < target - 500) ? 0 : 25;
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (fr_count >= BS_JUNK_ENTRY) begin
          send_resync(FLAG_CLEAR, 16'($urandom), ($urandom_range(1) != 0) ? SMB1_ID : SMB2_ID,
                      pick_offset());
        end else if (fr_count != BS_FIRST) begin
          send_noise(4 - int'(fr_count));
        end
        k    = $urandom_range(5);
        kind = (k == 0) ? TYPE_MESSAGE : 8'(TYPE_REQUEST + k - 1);
        if ($urandom_range(9) == 0) begin
          kind = 8'($urandom);
        end
        flag = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        send_header(kind, flag, 16'($urandom), pick_id(), $urandom_range(9) != 0,
                    pick_offset());
      end else if (pick < 80) begin
        send_header(8'($urandom_range(8'h80, 8'h01)), 8'($urandom), 16'($urandom), pick_id(),
                    1'($urandom_range(1)), pick_offset());
        send_noise($urandom_range(5));
        flag = ($urandom_range(6) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        send_resync(flag, 16'($urandom), ($urandom_range(6) == 0) ? pick_id() :
                    (($urandom_range(1) != 0) ? SMB1_ID : SMB2_ID), pick_offset());
      end else begin
        send_noise($urandom_range(8, 1));
      end
    end
    idle_pct = 25;
  endtask

  task automatic check_result();
    out_item_t want;
    if (pending_splits.size() == 0) begin
      report_mismatch($sformatf("result status %0d with nothing pending", out_if.status));
    end else begin
      want = pending_splits.pop_front();
      if (out_if.status !== want.status) begin
        report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
      end
      if (out_if.flush_point !== want.flush_point) begin
        report_mismatch($sformatf("flush_point %h, want %h", out_if.flush_point,
                                  want.flush_point));
      end
    end
  endtask

  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        check_result();
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        out_if.ready <= 1'b0;
        hold_left    = hold_request - 1;
        hold_request = 0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    int drain_cycles;
    drain_cycles      = 0;
    fr_count          = BS_FIRST;
    fr_shift          = '0;
    words_sent        = 0;
    err_count         = 0;
    idle_pct          = 25;
    hold_request      = 0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.seg_offset  = '0;
    in_if.ahead_word  = '0;
    in_if.ahead_valid = 1'b0;
    in_if.abort_req   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_session_headers();
    test_abort();
    test_junk_resync();
    test_backpressure();
    test_random_stream();
    in_if.valid <= 1'b0;
    while (pending_splits.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_splits.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_splits.size()));
    end
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/nbsmb_pkg.sv
rtl/nbsmb_in_if.sv
rtl/nbsmb_out_if.sv
rtl/nbsmb_step.sv
rtl/netbios_smb_pdu_splitter.sv
sim/testbench.sv
